// File: design/awb_pkg.sv
// Shared types and constants for the audio waveshaper and bitcrusher.
// Holds the sequencer state type, the multiplier request struct and the
// fixed-point constants of the shaping curves. No dependencies.
package awb_pkg;

   // Internal values carry 28 fraction bits.
   localparam int unsigned FB = 28;
   localparam int unsigned DW = 64;
   localparam logic signed [DW-1:0] ONE = 64'sd268435456;
   localparam logic signed [DW-1:0] SOFT_LIMIT = 64'sd241591910;
   localparam logic signed [DW-1:0] SIN_C9 = 64'sd43068;
   // Reciprocal of three, rounded up, with 32 fraction bits.
   localparam logic signed [DW-1:0] RECIP3 = 64'sd1431655766;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_PRE_GAIN    = 3'd0,
      CSR_DRIVE_GAIN  = 3'd1,
      CSR_POST_GAIN   = 3'd2,
      CSR_SHAPE_MODE  = 3'd3,
      CSR_CRUSH_DEPTH = 3'd4,
      CSR_HOLD_FACTOR = 3'd5
   } csr_index_type;

   // Shaping modes.
   typedef enum logic [2:0] {
      MODE_HARD   = 3'd0,
      MODE_SOFT   = 3'd1,
      MODE_WRAP   = 3'd2,
      MODE_SINE   = 3'd3,
      MODE_TANH   = 3'd4,
      MODE_SHAPER = 3'd5,
      MODE_BYPASS = 3'd6,
      MODE_SPARE  = 3'd7
   } mode_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRE,
      ST_GAIN,
      ST_SQ,
      ST_CUBE,
      ST_DIV3,
      ST_SH_G,
      ST_FIN_G,
      ST_SIN_U2,
      ST_SIN_POLY,
      ST_SIN_OUT,
      ST_TH_SQ,
      ST_TH_P,
      ST_TH_Q,
      ST_TH_DIV,
      ST_TH_Y,
      ST_CRUSH,
      ST_POST,
      ST_OUT
   } state_type;

   // Request to the shared multiplier.
   typedef struct packed {
      logic       start;
      logic [5:0] shift;
      logic       rnd;
   } mul_req_type;

   // Sine polynomial coefficients, applied from the highest order down.
   function automatic logic signed [DW-1:0] sin_coef(input logic [1:0] idx);
      logic signed [DW-1:0] c;
      unique case (idx)
         2'd0: c = 64'sd1256748;
         2'd1: c = 64'sd21392326;
         2'd2: c = 64'sd173399667;
         2'd3: c = 64'sd421657428;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Tanh numerator and denominator constants, 16 fraction bits.
   function automatic logic signed [DW-1:0] th_p_coef(input logic idx);
      return idx ? (64'sd135135 <<< 16) : (64'sd17325 <<< 16);
   endfunction

   function automatic logic signed [DW-1:0] th_q_coef(input logic idx);
      return idx ? (64'sd135135 <<< 16) : (64'sd62370 <<< 16);
   endfunction

endpackage

// File: design/awb_mul.sv
// Shared multiplier of the waveshaper: a 48 by 17 bit unsigned core used
// twice per product, then sign, rounding and right shift.
// Depends on awb_pkg.
module awb_mul
   import awb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mul_req_type          req,
   input  logic signed [DW-1:0] op_a,
   input  logic signed [DW-1:0] op_b,
   output logic                 done,
   output logic signed [DW-1:0] result
);

   logic [47:0]          mag_a_ff, mag_a_in;
   logic [33:0]          mag_b_ff, mag_b_in;
   logic                 neg_ff, neg_in;
   logic [81:0]          acc_ff, acc_in;
   logic [1:0]           phase_ff, phase_in;
   logic [5:0]           sh_ff, sh_in;
   logic                 rnd_ff, rnd_in;
   logic                 done_ff, done_in;
   logic signed [DW-1:0] result_ff, result_in;

   logic signed [DW-1:0] abs_a, abs_b;
   logic [16:0]          digit;
   logic [64:0]          partial;
   logic signed [82:0]   prod, rounded;

   assign abs_a = op_a[DW-1] ? -op_a : op_a;
   assign abs_b = op_b[DW-1] ? -op_b : op_b;

   // One digit of the multiplier operand per pass through the core.
   always_comb begin
      digit   = (phase_ff == 2'd1) ? mag_b_ff[16:0] : mag_b_ff[33:17];
      partial = mag_a_ff * digit;
      prod    = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      rounded = prod + (rnd_ff ? (83'sd1 <<< (sh_ff - 6'd1)) : 83'sd0);
   end

   always_comb begin
      mag_a_in  = mag_a_ff;
      mag_b_in  = mag_b_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      phase_in  = phase_ff;
      sh_in     = sh_ff;
      rnd_in    = rnd_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (phase_ff)
         2'd0: begin
            if (req.start) begin
               mag_a_in = abs_a[47:0];
               mag_b_in = abs_b[33:0];
               neg_in   = op_a[DW-1] ^ op_b[DW-1];
               acc_in   = '0;
               sh_in    = req.shift;
               rnd_in   = req.rnd;
               phase_in = 2'd1;
            end
         end
         2'd1: begin
            acc_in   = 82'(partial);
            phase_in = 2'd2;
         end
         2'd2: begin
            acc_in   = acc_ff + (82'(partial) << 17);
            phase_in = 2'd3;
         end
         2'd3: begin
            result_in = DW'(rounded >>> sh_ff);
            done_in   = 1'b1;
            phase_in  = 2'd0;
         end
         default: phase_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      mag_a_ff  <= mag_a_in;
      mag_b_ff  <= mag_b_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      rnd_ff    <= rnd_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: design/audio_waveshaper_bitcrusher_top.sv
// Audio waveshaper and bitcrusher: top level with the sequencer and datapath.
// Depends on awb_pkg and awb_mul.
//
// One sample at a time: a sample is taken when the sequencer is idle. Its
// result leaves through an output register, so the next sample may enter while
// the last result still waits. All products go through one shared multiplier.
// A product passes through the load, the core passes and the rounding and
// shift inside the multiplier, and its result is then handed over. Tanh mode
// takes the longest, as the 24-step restoring divider adds to its nine
// products. The sequencer waits in its last state while the output register
// still holds an untaken result. Configuration writes are always accepted
// and are used by every later step, so they belong between samples, while
// nothing is in flight.
module audio_waveshaper_bitcrusher_top
   import awb_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: sample_in [SAMPLE_BITS-1:0], zero padded to bytes
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // tdata: sample_out [31:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [2:0]                           csr_index,
   input  logic [15:0]                          csr_data
);

   localparam int LSH = (SAMPLE_BITS - 1 <= FB) ? FB - (SAMPLE_BITS - 1) : 0;
   localparam int RSH = (SAMPLE_BITS - 1 > FB) ? (SAMPLE_BITS - 1) - FB : 0;

   // Configuration registers.
   logic [15:0] pre_gain_ff, drive_gain_ff, post_gain_ff;
   logic [2:0]  shape_mode_ff;
   logic [5:0]  crush_depth_ff, hold_factor_ff;

   state_type            state_ff, state_in;
   logic                 pend_ff;
   logic [4:0]           cnt_ff;
   logic signed [DW-1:0] x_ff, v_ff, w_ff, t_ff, u_ff, r_ff, m_ff, x2_ff, p_ff, q_ff;
   logic [1:0]           quad_ff;
   logic                 neg_ff;
   logic [48:0]          rem_ff;
   logic [5:0]           hold_count_ff;
   logic signed [31:0]   held_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;

   mul_req_type          mul_req;
   logic signed [DW-1:0] op_a, op_b, mul_res;
   logic                 mul_done;
   logic                 mul_state;

   logic signed [DW-1:0] sample_ext, gain_g, wrap_sum, ph_f, abs_res;
   logic [48:0]          rem_sh;
   logic                 div_ge;
   logic [23:0]          div_low;
   logic [4:0]           depth;
   logic signed [DW-1:0] crush_mask, crush_mag, crush_t, crush_c;
   logic signed [31:0]   crush_sat, post_sat;
   logic [4:0]           hold_len;
   logic [5:0]           hold_next;
   logic                 hold_restart;
   mode_type             mode;

   awb_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (mul_done),
      .result (mul_res)
   );

   assign mode       = mode_type'(shape_mode_ff);
   assign gain_g     = DW'(drive_gain_ff);
   assign sample_ext = (DW'($signed(req_tdata[SAMPLE_BITS-1:0])) <<< LSH) >>> RSH;
   assign abs_res    = mul_res[DW-1] ? -mul_res : mul_res;
   assign wrap_sum   = mul_res + ONE;
   assign ph_f       = DW'(mul_res[27:0]);

   // Configuration write channel.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_gain_ff    <= 16'd8192;
         drive_gain_ff  <= 16'd16384;
         post_gain_ff   <= 16'd16384;
         shape_mode_ff  <= MODE_BYPASS;
         crush_depth_ff <= 6'd32;
         hold_factor_ff <= 6'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRE_GAIN:    pre_gain_ff    <= csr_data;
            CSR_DRIVE_GAIN:  drive_gain_ff  <= csr_data;
            CSR_POST_GAIN:   post_gain_ff   <= csr_data;
            CSR_SHAPE_MODE:  shape_mode_ff  <= csr_data[2:0];
            CSR_CRUSH_DEPTH: crush_depth_ff <= csr_data[5:0];
            CSR_HOLD_FACTOR: hold_factor_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Divider step: one quotient bit per cycle.
   always_comb begin
      div_low = {p_ff[3:0], 20'd0};
      rem_sh  = {rem_ff[47:0], div_low[cnt_ff]};
      div_ge  = rem_sh >= q_ff[48:0];
   end

   // Truncation toward zero to the quantizer step, then hold bookkeeping.
   always_comb begin
      depth        = (crush_depth_ff > 6'd23) ? 5'd23 : crush_depth_ff[4:0];
      crush_mask   = (64'sd1 <<< (5'd28 - depth)) - 64'sd1;
      crush_mag    = (t_ff[DW-1] ? -t_ff : t_ff) & ~crush_mask;
      crush_t      = t_ff[DW-1] ? -crush_mag : crush_mag;
      crush_c      = crush_t >>> 5;
      crush_sat    = (crush_c > 64'sd2147483647) ? 32'sh7fffffff :
                     (crush_c < -64'sd2147483648) ? 32'sh80000000 : 32'(crush_c);
      post_sat     = (mul_res > 64'sd2147483647) ? 32'sh7fffffff :
                     (mul_res < -64'sd2147483648) ? 32'sh80000000 : 32'(mul_res);
      hold_len     = hold_factor_ff[5:1];
      hold_restart = (hold_count_ff == 6'd0) || (hold_count_ff >= 6'(hold_len));
      hold_next    = (hold_restart ? 6'd0 : hold_count_ff) + 6'd1;
      if (hold_next >= 6'(hold_len)) begin
         hold_next = 6'd0;
      end
   end

   // Next state and multiplier operands.
   always_comb begin
      state_in  = state_ff;
      op_a      = '0;
      op_b      = '0;
      mul_state = 1'b1;
      mul_req   = '{start: 1'b0, shift: 6'd14, rnd: 1'b1};
      unique case (state_ff)
         ST_IDLE: begin
            mul_state = 1'b0;
            if (req_tvalid) state_in = ST_PRE;
         end
         ST_PRE: begin
            op_a = x_ff;
            op_b = DW'(pre_gain_ff);
            if (mul_done) begin
               priority case (mode)
                  MODE_HARD, MODE_WRAP, MODE_SINE, MODE_TANH: state_in = ST_GAIN;
                  MODE_SOFT: state_in = (mul_res < -ONE || mul_res > ONE) ? ST_CRUSH : ST_SQ;
                  MODE_SHAPER: state_in = ST_SQ;
                  default: state_in = ST_CRUSH;
               endcase
            end
         end
         ST_GAIN: begin
            op_a = v_ff;
            op_b = gain_g;
            if (mul_done) begin
               priority case (mode)
                  MODE_SINE: state_in = ST_SIN_U2;
                  MODE_TANH: state_in = ST_TH_SQ;
                  default:   state_in = ST_CRUSH;
               endcase
            end
         end
         ST_SQ: begin
            op_a          = v_ff;
            op_b          = v_ff;
            mul_req.shift = 6'd28;
            if (mul_done) state_in = (mode == MODE_SOFT) ? ST_CUBE : ST_SH_G;
         end
         ST_CUBE: begin
            op_a          = w_ff;
            op_b          = v_ff;
            mul_req.shift = 6'd28;
            if (mul_done) state_in = ST_DIV3;
         end
         ST_DIV3: begin
            op_a          = w_ff[DW-1] ? -w_ff : w_ff;
            op_b          = RECIP3;
            mul_req.shift = 6'd32;
            mul_req.rnd   = 1'b0;
            if (mul_done) state_in = ST_FIN_G;
         end
         ST_SH_G: begin
            op_a = w_ff;
            op_b = gain_g;
            if (mul_done) state_in = ST_FIN_G;
         end
         ST_FIN_G: begin
            op_a = w_ff;
            op_b = gain_g;
            if (mul_done) state_in = ST_CRUSH;
         end
         ST_SIN_U2: begin
            op_a          = u_ff;
            op_b          = u_ff;
            mul_req.shift = 6'd28;
            if (mul_done) state_in = ST_SIN_POLY;
         end
         ST_SIN_POLY: begin
            op_a          = r_ff;
            op_b          = w_ff;
            mul_req.shift = 6'd28;
            if (mul_done && cnt_ff == 5'd3) state_in = ST_SIN_OUT;
         end
         ST_SIN_OUT: begin
            op_a          = r_ff;
            op_b          = u_ff;
            mul_req.shift = 6'd28;
            if (mul_done) state_in = ST_CRUSH;
         end
         ST_TH_SQ: begin
            op_a          = m_ff;
            op_b          = m_ff;
            mul_req.shift = 6'd40;
            mul_req.rnd   = 1'b0;
            if (mul_done) state_in = ST_TH_P;
         end
         ST_TH_P: begin
            op_a          = p_ff;
            op_b          = x2_ff;
            mul_req.shift = 6'd16;
            mul_req.rnd   = 1'b0;
            if (mul_done && cnt_ff == 5'd1) state_in = ST_TH_Q;
         end
         ST_TH_Q: begin
            op_a          = q_ff;
            op_b          = x2_ff;
            mul_req.shift = 6'd16;
            mul_req.rnd   = 1'b0;
            if (mul_done && cnt_ff == 5'd1) state_in = ST_TH_DIV;
         end
         ST_TH_DIV: begin
            mul_state = 1'b0;
            if (cnt_ff == 5'd0) state_in = ST_TH_Y;
         end
         ST_TH_Y: begin
            op_a          = m_ff;
            op_b          = r_ff;
            mul_req.shift = 6'd20;
            if (mul_done) state_in = ST_CRUSH;
         end
         ST_CRUSH: begin
            mul_state = 1'b0;
            state_in  = ST_POST;
         end
         ST_POST: begin
            op_a = DW'(held_ff);
            op_b = DW'(post_gain_ff);
            if (mul_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            mul_state = 1'b0;
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            mul_state = 1'b0;
            state_in  = ST_IDLE;
         end
      endcase
      mul_req.start = mul_state && !pend_ff;
   end

   // Sequencer control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         hold_count_ff <= 6'd0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_req.start) begin
            pend_ff <= 1'b1;
         end else if (mul_done) begin
            pend_ff <= 1'b0;
         end
         if (state_ff == ST_CRUSH) begin
            if (hold_len <= 5'd1) begin
               held_ff       <= crush_sat;
               hold_count_ff <= 6'd0;
            end else begin
               if (hold_restart) held_ff <= crush_sat;
               hold_count_ff <= hold_next;
            end
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers, written on each sample, product and divider step.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) x_ff <= sample_ext;
         end
         ST_PRE: begin
            if (mul_done) begin
               v_ff <= mul_res;
               if (mode == MODE_SOFT && mul_res < -ONE) t_ff <= -SOFT_LIMIT;
               else if (mode == MODE_SOFT && mul_res > ONE) t_ff <= SOFT_LIMIT;
               else t_ff <= mul_res;
            end
         end
         ST_GAIN: begin
            if (mul_done) begin
               priority case (mode)
                  MODE_HARD: t_ff <= (mul_res > ONE) ? ONE : (mul_res < -ONE) ? -ONE : mul_res;
                  MODE_WRAP: t_ff <= DW'(wrap_sum[28:0]) - ONE;
                  MODE_SINE: begin
                     quad_ff <= mul_res[29:28];
                     u_ff    <= mul_res[28] ? ONE - ph_f : ph_f;
                     r_ff    <= SIN_C9;
                     cnt_ff  <= 5'd0;
                  end
                  default: begin
                     m_ff   <= abs_res;
                     neg_ff <= mul_res[DW-1];
                  end
               endcase
            end
         end
         ST_SQ, ST_CUBE: begin
            if (mul_done) w_ff <= mul_res;
         end
         ST_DIV3: begin
            if (mul_done) w_ff <= v_ff - (w_ff[DW-1] ? -mul_res : mul_res);
         end
         ST_SH_G: begin
            if (mul_done) w_ff <= v_ff + mul_res;
         end
         ST_FIN_G: begin
            if (mul_done) t_ff <= mul_res;
         end
         ST_SIN_U2: begin
            if (mul_done) w_ff <= mul_res;
         end
         ST_SIN_POLY: begin
            if (mul_done) begin
               r_ff   <= sin_coef(cnt_ff[1:0]) - mul_res;
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         ST_SIN_OUT: begin
            if (mul_done) t_ff <= quad_ff[1] ? -mul_res : mul_res;
         end
         ST_TH_SQ: begin
            if (mul_done) begin
               x2_ff  <= mul_res;
               p_ff   <= (64'sd378 <<< 16) + mul_res;
               q_ff   <= (64'sd3150 <<< 16) + (mul_res <<< 5) - (mul_res <<< 2);
               cnt_ff <= 5'd0;
            end
         end
         ST_TH_P: begin
            if (mul_done) begin
               p_ff   <= th_p_coef(cnt_ff[0]) + mul_res;
               cnt_ff <= (cnt_ff == 5'd1) ? 5'd0 : cnt_ff + 5'd1;
            end
         end
         ST_TH_Q: begin
            if (mul_done) begin
               q_ff <= th_q_coef(cnt_ff[0]) + mul_res;
               if (cnt_ff == 5'd1) begin
                  cnt_ff <= 5'd23;
                  rem_ff <= 49'(p_ff >>> 4);
                  r_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
         end
         ST_TH_DIV: begin
            rem_ff <= div_ge ? rem_sh - q_ff[48:0] : rem_sh;
            r_ff   <= {r_ff[DW-2:0], div_ge};
            cnt_ff <= cnt_ff - 5'd1;
         end
         ST_TH_Y: begin
            if (mul_done) t_ff <= neg_ff ? -mul_res : mul_res;
         end
         ST_OUT: begin
            // The post-gain product stays in the multiplier until the
            // output register is free.
            if (!rsp_valid_ff || rsp_tready) rsp_data_ff <= post_sat;
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/awb_checker.sv
// Result checker for the audio waveshaper and bitcrusher testbench.
// Watches the sample, result and register channels, predicts every result
// and compares. Depends on awb_pkg for register indexes and mode codes.
module awb_checker
   import awb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam longint FRAC_ONE = 64'sd268435456;

   // Shadow copy of the registers and of the hold state.
   logic [15:0] pre_gain, drive_gain, post_gain;
   logic [2:0]  shape_mode;
   logic [5:0]  crush_depth, hold_factor;
   logic [5:0]  hold_count;
   logic signed [31:0] held_value;

   logic [31:0] expected_samples[$];
   int          result_count;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic longint round_mul(longint a, longint b, int s);
      return (a * b + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Odd polynomial for the first quarter turn of the sine.
   function automatic longint sine_quarter_turn(longint u);
      longint u2, r;
      u2 = round_mul(u, u, 28);
      r = 64'sd1256748 - round_mul(u2, 64'sd43068, 28);
      r = 64'sd21392326 - round_mul(u2, r, 28);
      r = 64'sd173399667 - round_mul(u2, r, 28);
      r = 64'sd421657428 - round_mul(u2, r, 28);
      return round_mul(u, r, 28);
   endfunction

   function automatic longint sine_of_phase(longint ph);
      bit [63:0] p, q;
      longint f, u, s;
      p = ph & (4 * FRAC_ONE - 1);
      q = p >> 28;
      f = p & (FRAC_ONE - 1);
      u = q[0] ? FRAC_ONE - f : f;
      s = sine_quarter_turn(u);
      return q[1] ? -s : s;
   endfunction

   // Rational tanh approximation, all in unsigned 64-bit arithmetic.
   function automatic longint tanh_of(longint t);
      bit [63:0] m, x2, p, q, r, y;
      m = (t < 0) ? -t : t;
      x2 = (m * m) >> 40;
      p = (64'd378 << 16) + x2;
      q = (64'd3150 << 16) + 64'd28 * x2;
      p = (64'd17325 << 16) + ((x2 * p) >> 16);
      p = (64'd135135 << 16) + ((x2 * p) >> 16);
      q = (64'd62370 << 16) + ((x2 * q) >> 16);
      q = (64'd135135 << 16) + ((x2 * q) >> 16);
      r = (p << 20) / q;
      y = (m * r + (64'd1 << 19)) >> 20;
      return (t < 0) ? -longint'(y) : longint'(y);
   endfunction

   // Full chain for one sample; advances the hold state.
   function automatic logic [31:0] shaped_sample(logic signed [23:0] sample);
      longint x, v, t, g, v3, step;
      int unsigned depth, group_len;
      logic signed [31:0] crushed;
      g = drive_gain;
      x = longint'(sample) * 32;
      v = round_mul(x, pre_gain, 14);
      case (mode_type'(shape_mode))
         MODE_HARD: begin
            t = round_mul(g, v, 14);
            if (t > FRAC_ONE) t = FRAC_ONE;
            if (t < -FRAC_ONE) t = -FRAC_ONE;
         end
         MODE_SOFT: begin
            if (v < -FRAC_ONE) t = -64'sd241591910;
            else if (v > FRAC_ONE) t = 64'sd241591910;
            else begin
               v3 = round_mul(round_mul(v, v, 28), v, 28);
               t = round_mul(g, v - v3 / 3, 14);
            end
         end
         MODE_WRAP: begin
            t = round_mul(g, v, 14) + FRAC_ONE;
            t = (t & (2 * FRAC_ONE - 1)) - FRAC_ONE;
         end
         MODE_SINE:   t = sine_of_phase(round_mul(g, v, 14));
         MODE_TANH:   t = tanh_of(round_mul(g, v, 14));
         MODE_SHAPER: t = round_mul(g, v + round_mul(g, round_mul(v, v, 28), 14), 14);
         default:     t = v;
      endcase
      // Truncate toward zero to the crush step, then go to 23 fraction bits.
      depth = (crush_depth > 23) ? 23 : crush_depth;
      step = 64'sd1 <<< (28 - depth);
      t = t - t % step;
      crushed = 32'(clamp32(t / 32));
      group_len = hold_factor >> 1;
      if (group_len <= 1) begin
         held_value = crushed;
         hold_count = 0;
      end else begin
         if (hold_count == 0 || hold_count >= group_len) begin
            held_value = crushed;
            hold_count = 0;
         end
         hold_count++;
         if (hold_count >= group_len) hold_count = 0;
      end
      return 32'(clamp32(round_mul(held_value, post_gain, 14)));
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch at result %0d: %s expected %h got %h", result_count, what, want, got);
      fail_count++;
   endtask

   // Predict on each sample transfer, compare on each result transfer.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         pre_gain = 16'd8192;
         drive_gain = 16'd16384;
         post_gain = 16'd16384;
         shape_mode = MODE_BYPASS;
         crush_depth = 6'd32;
         hold_factor = 6'd0;
         hold_count = 0;
         held_value = 0;
         result_count = 0;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PRE_GAIN:    pre_gain = csr_data;
               CSR_DRIVE_GAIN:  drive_gain = csr_data;
               CSR_POST_GAIN:   post_gain = csr_data;
               CSR_SHAPE_MODE:  shape_mode = csr_data[2:0];
               CSR_CRUSH_DEPTH: crush_depth = csr_data[5:0];
               CSR_HOLD_FACTOR: hold_factor = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_samples.push_back(shaped_sample(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_tdata);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== want) report_mismatch("sample_out", want, rsp_tdata);
            end
            result_count++;
         end
      end
      pending = expected_samples.size();
   end

endmodule

// File: tb/audio_waveshaper_bitcrusher_top_tb.sv
// Testbench top for the audio waveshaper and bitcrusher.
// Drives samples and register writes, varies back-pressure and gives the
// verdict. Depends on awb_pkg, awb_checker and the block itself.
module audio_waveshaper_bitcrusher_top_tb;
   import awb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int fail_count, pending;
   int send_idle_pct = 11;
   int recv_idle_pct = 66;
   int stall_cycles = 0;
   int cycle_count = 0;
   int samples_sent = 0;
   int settings_used = 0;

   audio_waveshaper_bitcrusher_top #(.SAMPLE_BITS(24)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   awb_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial forever #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: random back-pressure, or a long hold-off when requested.
   initial forever begin
      @(negedge clock);
      if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One sample transfer, with random idle cycles ahead of it.
   task automatic send_sample(logic [23:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   // Writes all six registers once the block has drained.
   task automatic write_settings(logic [15:0] pre, logic [15:0] drive, logic [15:0] post,
                                 logic [15:0] mode, logic [15:0] depth, logic [15:0] hold);
      logic [15:0] vals[6];
      vals = '{pre, drive, post, mode, depth, hold};
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($signed($urandom_range(255)) - 128);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(9))
         0: return 16'd1638;
         1: return 16'd32768;
         2: return 16'($urandom_range(65535, 32769));
         default: return 16'($urandom_range(32768, 1638));
      endcase
   endfunction

   initial begin
      logic [15:0] depth, hold;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: bypass at reset values, field extremes.
      send_sample(24'h000000);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'hFFFFFF);
      send_sample(24'h000001);
      // Every mode, including the spare code, at a gain of two.
      for (int m = MODE_HARD; m <= MODE_SPARE; m++) begin
         write_settings(16'd32768, 16'd32768, 16'd32768, 16'(m), 16'd23, 16'd0);
         send_sample(24'h7FFFFF);
         send_sample(24'h800000);
      end
      // Soft clip exactly at plus and minus one takes the cubic branch.
      write_settings(16'd32768, 16'd16384, 16'd16384, MODE_SOFT, 16'd32, 16'd0);
      send_sample(24'h400000);
      send_sample(24'hC00000);
      // Crush depth zero, gains beyond two, and a held group of five.
      write_settings(16'd65535, 16'd65535, 16'd65535, MODE_SHAPER, 16'd0, 16'd10);
      send_sample(24'h123456);
      send_sample(24'hEDCBA9);
      send_sample(24'h7FFFFF);

      // Random phases: three idling patterns, settings change per phase.
      for (int phase = 0; phase < 18; phase++) begin
         if (phase == 6) begin
            send_idle_pct = 66;
            recv_idle_pct = 11;
         end else if (phase == 12) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(5))
            0: depth = 16'd0;
            1: depth = 16'd63;
            2: depth = 16'd23;
            default: depth = 16'($urandom_range(32, 1));
         endcase
         case ($urandom_range(4))
            0: hold = 16'd0;
            1: hold = 16'd63;
            2: hold = 16'd50;
            default: hold = 16'($urandom_range(12));
         endcase
         write_settings(random_gain(), random_gain(), random_gain(),
                        16'($urandom_range(7)), depth, hold);
         for (int n = 0; n < 105; n++) begin
            // Long result hold-off while samples keep coming.
            if (phase == 14 && n == 10) begin
               @(posedge clock);
               stall_cycles = 400;
            end
            send_sample(random_sample());
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Run covered %0d samples over %0d register settings and all shaping modes,",
               samples_sent, settings_used);
      $display("with three back-pressure patterns and one long result stall.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/awb_pkg.sv
design/awb_mul.sv
design/audio_waveshaper_bitcrusher_top.sv
tb/awb_checker.sv
tb/audio_waveshaper_bitcrusher_top_tb.sv
